// ===== sv/ms_pkg.sv =====
// ms_pkg: shared types and constants for the max_stack block
// no dependencies; used by the interfaces, the cells, the controller and the checker
package ms_pkg;

  localparam int WORD_W   = 32;
  localparam int MODE_W   = 2;
  localparam int TOTAL_W  = 7;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_POPMAX = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_UP,
    SH_DOWN
  } shift_t;

endpackage

// ===== sv/ms_req_if.sv =====
// ms_req_if: request channel of max_stack (operation and push value)
// depends on ms_pkg for field widths
interface ms_req_if;
  logic                              valid;
  logic                              ready;
  logic [ms_pkg::MODE_W-1:0]         mode;
  logic signed [ms_pkg::WORD_W-1:0]  push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

// ===== sv/ms_rsp_if.sv =====
// ms_rsp_if: response channel of max_stack (removed value and stack summary)
// depends on ms_pkg for field widths
interface ms_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [ms_pkg::WORD_W-1:0]  removed_value;
  logic signed [ms_pkg::WORD_W-1:0]  top_value;
  logic signed [ms_pkg::WORD_W-1:0]  max_value;
  logic [ms_pkg::TOTAL_W-1:0]        entry_total;
  logic                              is_empty;
  logic [ms_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output removed_value, output top_value, output max_value,
                  output entry_total, output is_empty, output status, input ready);
  modport sink   (input valid, input removed_value, input top_value, input max_value,
                  input entry_total, input is_empty, input status, output ready);
endinterface

// ===== sv/max_stack.sv =====
// max_stack: top level, a ring of ms_cell entries run by ms_ctrl
// depends on ms_pkg, ms_req_if, ms_rsp_if, ms_cell and ms_ctrl
//
// usage
//   req carries one operation per transaction: mode push, pop, pop maximum or
//   no-op, and push_value for a push. rsp returns one transaction per request with
//   the removed value and the top, maximum, count, empty flag and status of
//   the stack after the operation.
//   entries live in a row of STACK_DEPTH cells, the top in cell 0. push and
//   pop shift the row by one place in the cycle the request is accepted; pop
//   maximum closes the gap below the top-most maximum in that same cycle.
//   after every operation the row rotates once all the way round, while the
//   controller watches cell 0 to find the maximum and its place for the next
//   pop maximum.
//   rsp.valid rises when the rotation pass through the ring is done; a new
//   request cannot be taken before that pass ends.
//   one request is in flight at a time; req.ready is low until rsp is taken,
//   and a stalled rsp holds its payload.
//   reset (rst, synchronous) empties the stack; cell contents are not cleared.
module max_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  ms_req_if.sink    req,
  ms_rsp_if.source  rsp
);

  localparam int IW = $clog2(STACK_DEPTH);

  ms_pkg::shift_t                    shift;
  logic [IW-1:0]                     cut;
  logic signed [ms_pkg::WORD_W-1:0]  cell_q [STACK_DEPTH];

  ms_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .top   (cell_q[0]),
    .shift (shift),
    .cut   (cut)
  );

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic signed [ms_pkg::WORD_W-1:0] d_up;
    logic signed [ms_pkg::WORD_W-1:0] d_down;
    logic                             sel;

    if (i == 0) begin : g_first
      assign d_up = req.push_value;
    end else begin : g_mid
      assign d_up = cell_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign d_down = cell_q[0];
    end else begin : g_inner
      assign d_down = cell_q[i+1];
    end

    assign sel = (IW'(i) >= cut);

    ms_cell u_cell (
      .clk    (clk),
      .shift  (shift),
      .sel    (sel),
      .d_up   (d_up),
      .d_down (d_down),
      .q      (cell_q[i])
    );
  end

endmodule

// ===== sv/ms_cell.sv =====
// ms_cell: one stack entry of the cell row, loads from its upper or lower neighbor
// depends on ms_pkg (shift_t, WORD_W)
module ms_cell (
  input  logic                              clk,
  input  ms_pkg::shift_t                    shift,
  input  logic                              sel,
  input  logic signed [ms_pkg::WORD_W-1:0]  d_up,
  input  logic signed [ms_pkg::WORD_W-1:0]  d_down,
  output logic signed [ms_pkg::WORD_W-1:0]  q
);

  always_ff @(posedge clk) begin
    case (shift)
      ms_pkg::SH_UP: begin
        q <= d_up;
      end
      ms_pkg::SH_DOWN: begin
        if (sel) begin
          q <= d_down;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

// ===== sv/ms_ctrl.sv =====
// ms_ctrl: operation sequencer, entry count and max scan for max_stack
// depends on ms_pkg, ms_req_if and ms_rsp_if; drives the shift of the ms_cell row
module ms_ctrl #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  ms_req_if.sink                            req,
  ms_rsp_if.source                          rsp,
  input  logic signed [ms_pkg::WORD_W-1:0]  top,
  output ms_pkg::shift_t                    shift,
  output logic [$clog2(STACK_DEPTH)-1:0]    cut
);

  localparam int IW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  ms_pkg::state_t                    state, state_next;
  logic [CW-1:0]                     count, count_next;
  logic [IW-1:0]                     scan, scan_next;
  logic signed [ms_pkg::WORD_W-1:0]  best, best_next;
  logic [IW-1:0]                     best_idx, best_idx_next;
  logic                              found, found_next;
  logic signed [ms_pkg::WORD_W-1:0]  removed, removed_next;
  ms_pkg::status_t                   status, status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ms_pkg::S_IDLE;
      count <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    scan     <= scan_next;
    best     <= best_next;
    best_idx <= best_idx_next;
    removed  <= removed_next;
    status   <= status_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_next     = scan;
    best_next     = best;
    best_idx_next = best_idx;
    found_next    = found;
    removed_next  = removed;
    status_next   = status;
    shift         = ms_pkg::SH_HOLD;
    cut           = '0;
    req.ready     = (state == ms_pkg::S_IDLE);
    rsp.valid     = (state == ms_pkg::S_DONE);
    unique case (state)
      ms_pkg::S_IDLE: begin
        if (req.valid) begin
          removed_next = '0;
          status_next  = ms_pkg::STAT_OK;
          scan_next    = '0;
          found_next   = 1'b0;
          state_next   = ms_pkg::S_SCAN;
          unique case (ms_pkg::mode_t'(req.mode))
            ms_pkg::MODE_PUSH: begin
              if (count == CW'(STACK_DEPTH)) begin
                status_next = ms_pkg::STAT_FULL;
              end else begin
                shift      = ms_pkg::SH_UP;
                count_next = count + CW'(1);
              end
            end
            ms_pkg::MODE_POP: begin
              if (count == '0) begin
                status_next = ms_pkg::STAT_EMPTY;
              end else begin
                removed_next = top;
                shift        = ms_pkg::SH_DOWN;
                count_next   = count - CW'(1);
              end
            end
            ms_pkg::MODE_POPMAX: begin
              if (count == '0) begin
                status_next = ms_pkg::STAT_EMPTY;
              end else begin
                removed_next = best;
                shift        = ms_pkg::SH_DOWN;
                cut          = best_idx;
                count_next   = count - CW'(1);
              end
            end
            ms_pkg::MODE_NOP: begin
              status_next = ms_pkg::STAT_OK;
            end
          endcase
        end
      end
      ms_pkg::S_SCAN: begin
        // full rotation of the ring, cell 0 shows entry number scan
        shift = ms_pkg::SH_DOWN;
        if ((CW'(scan) < count) && (!found || (top > best))) begin
          best_next     = top;
          best_idx_next = scan;
          found_next    = 1'b1;
        end
        scan_next = scan + IW'(1);
        if (scan == IW'(STACK_DEPTH - 1)) begin
          state_next = ms_pkg::S_DONE;
        end
      end
      ms_pkg::S_DONE: begin
        if (rsp.ready) begin
          state_next = ms_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ms_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp.removed_value = removed;
  assign rsp.top_value     = (count != '0) ? top : '0;
  assign rsp.max_value     = found ? best : '0;
  assign rsp.entry_total   = ms_pkg::TOTAL_W'(count);
  assign rsp.is_empty      = (count == '0);
  assign rsp.status        = status;

endmodule

// ===== sv/ms_check.sv =====
// ms_check: port-level assertions for max_stack, attached by bind
// depends on ms_pkg and the max_stack top level
module ms_check #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  input  logic                               req_ready,
  input  logic                               rsp_valid,
  input  logic                               rsp_ready,
  input  logic signed [ms_pkg::WORD_W-1:0]   removed_value,
  input  logic signed [ms_pkg::WORD_W-1:0]   top_value,
  input  logic signed [ms_pkg::WORD_W-1:0]   max_value,
  input  logic [ms_pkg::TOTAL_W-1:0]         entry_total,
  input  logic                               is_empty,
  input  logic [ms_pkg::STATUS_W-1:0]        status
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(removed_value) && $stable(status))
    else $error("stalled response changed");

  a_empty_view: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> top_value == '0 && max_value == '0)
    else $error("empty stack reports nonzero top or max");

  a_max_ge_top: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !is_empty |-> max_value >= top_value)
    else $error("maximum below top entry");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ms_pkg::STAT_FULL |->
      entry_total == ms_pkg::TOTAL_W'(STACK_DEPTH) && removed_value == '0)
    else $error("full status with wrong count");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid && !req_ready)
    else $error("request overlap");

endmodule

bind max_stack ms_check #(
  .STACK_DEPTH (STACK_DEPTH)
) u_ms_check (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .removed_value (rsp.removed_value),
  .top_value     (rsp.top_value),
  .max_value     (rsp.max_value),
  .entry_total   (rsp.entry_total),
  .is_empty      (rsp.is_empty),
  .status        (rsp.status)
);

// ===== dv/tb_max_stack.sv =====
// tb_max_stack: self-checking testbench for the max_stack block
// depends on ms_pkg, ms_req_if, ms_rsp_if and max_stack from the rtl
// directed table then random push/pop/pop-max/no-op phases, each response checked in order
`timescale 1ns / 100ps

module tb_max_stack;

  localparam int STACK_DEPTH  = 64;
  localparam int RANDOM_OPS   = 826;
  localparam int DIRECTED_OPS = 24;

  localparam logic signed [ms_pkg::WORD_W-1:0] WMAX = 32'sh7fffffff;
  localparam logic signed [ms_pkg::WORD_W-1:0] WMIN = 32'sh80000000;

  typedef struct {
    logic signed [ms_pkg::WORD_W-1:0] removed;
    logic signed [ms_pkg::WORD_W-1:0] top;
    logic signed [ms_pkg::WORD_W-1:0] maxv;
    logic [ms_pkg::TOTAL_W-1:0]       total;
    logic                             empty;
    ms_pkg::status_t                  status;
  } stack_summary_t;

  typedef struct {
    ms_pkg::mode_t                    mode;
    logic signed [ms_pkg::WORD_W-1:0] value;
    bit                               typed;
    stack_summary_t                   want;
  } directed_row_t;

  localparam stack_summary_t SUM_NONE      = '{'0, '0, '0, 7'd0, 1'b0, ms_pkg::STAT_OK};
  localparam stack_summary_t SUM_EMPTY_ERR = '{'0, '0, '0, 7'd0, 1'b1, ms_pkg::STAT_EMPTY};
  localparam stack_summary_t SUM_EMPTY_OK  = '{'0, '0, '0, 7'd0, 1'b1, ms_pkg::STAT_OK};

  logic clk;
  logic rst;

  ms_req_if req_ch ();
  ms_rsp_if rsp_ch ();

  max_stack #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  logic signed [ms_pkg::WORD_W-1:0] shadow_stack [$];
  stack_summary_t                   pending_summaries [$];
  directed_row_t                    directed_rows [DIRECTED_OPS];

  int  errors;
  int  op_count [4];
  int  full_rejects;
  int  empty_rejects;
  int  deepest;
  bit  quiet;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // index of the top-most largest entry, index 0 is the bottom
  function automatic int topmost_max_idx();
    int best;
    best = 0;
    for (int k = 1; k < shadow_stack.size(); k++) begin
      if (!(shadow_stack[best] > shadow_stack[k])) best = k;
    end
    return best;
  endfunction

  function automatic stack_summary_t apply_stack_op(ms_pkg::mode_t m,
                                                    logic signed [ms_pkg::WORD_W-1:0] v);
    stack_summary_t s;
    int             at;
    s = SUM_NONE;
    case (m)
      ms_pkg::MODE_PUSH: begin
        if (shadow_stack.size() >= STACK_DEPTH) s.status = ms_pkg::STAT_FULL;
        else shadow_stack.insert(shadow_stack.size(), v);
      end
      ms_pkg::MODE_POP, ms_pkg::MODE_POPMAX: begin
        if (shadow_stack.size() == 0) begin
          s.status = ms_pkg::STAT_EMPTY;
        end else if (m == ms_pkg::MODE_POP) begin
          s.removed = shadow_stack[shadow_stack.size()-1];
          shadow_stack.delete(shadow_stack.size()-1);
        end else begin
          at = topmost_max_idx();
          s.removed = shadow_stack[at];
          shadow_stack.delete(at);
        end
      end
      default: ;
    endcase
    if (shadow_stack.size() > 0) begin
      s.top  = shadow_stack[shadow_stack.size()-1];
      s.maxv = shadow_stack[topmost_max_idx()];
    end
    s.total = ms_pkg::TOTAL_W'(shadow_stack.size());
    s.empty = (shadow_stack.size() == 0);
    return s;
  endfunction

  task automatic send_op(input ms_pkg::mode_t m, input logic signed [ms_pkg::WORD_W-1:0] v,
                         input bit typed, input stack_summary_t want);
    int             gap;
    stack_summary_t predicted;
    gap = idle_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= m;
    req_ch.push_value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = apply_stack_op(m, v);
    op_count[m]++;
    if (predicted.status == ms_pkg::STAT_FULL) full_rejects++;
    if (predicted.status == ms_pkg::STAT_EMPTY) empty_rejects++;
    if (shadow_stack.size() > deepest) deepest = shadow_stack.size();
    pending_summaries.insert(pending_summaries.size(), typed ? want : predicted);
  endtask

  function automatic void flag_mismatch(string field, logic [ms_pkg::WORD_W-1:0] want,
                                        logic [ms_pkg::WORD_W-1:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    errors++;
  endfunction

  // response checker
  always @(posedge clk) begin : rsp_check
    stack_summary_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_summaries.size() == 0) begin
        flag_mismatch("unexpected transaction", '0, rsp_ch.removed_value);
      end else begin
        want = pending_summaries.pop_front();
        if (rsp_ch.removed_value !== want.removed)
          flag_mismatch("removed_value", want.removed, rsp_ch.removed_value);
        if (rsp_ch.top_value !== want.top)
          flag_mismatch("top_value", want.top, rsp_ch.top_value);
        if (rsp_ch.max_value !== want.maxv)
          flag_mismatch("max_value", want.maxv, rsp_ch.max_value);
        if (rsp_ch.entry_total !== want.total)
          flag_mismatch("entry_total", ms_pkg::WORD_W'(want.total),
                        ms_pkg::WORD_W'(rsp_ch.entry_total));
        if (rsp_ch.is_empty !== want.empty)
          flag_mismatch("is_empty", ms_pkg::WORD_W'(want.empty),
                        ms_pkg::WORD_W'(rsp_ch.is_empty));
        if (rsp_ch.status !== want.status)
          flag_mismatch("status", ms_pkg::WORD_W'(want.status),
                        ms_pkg::WORD_W'(rsp_ch.status));
      end
    end
  end

  // response backpressure
  initial begin : rsp_stall
    int stall;
    forever begin
      stall = idle_len();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int                               sent;
    int                               phase_left;
    int                               push_pct;
    int                               r;
    ms_pkg::mode_t                    m;
    logic signed [ms_pkg::WORD_W-1:0] v;

    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= ms_pkg::MODE_PUSH;
    req_ch.push_value <= '0;
    errors        = 0;
    full_rejects  = 0;
    empty_rejects = 0;
    deepest       = 0;
    quiet         = 1'b0;
    for (int i = 0; i < 4; i++) op_count[i] = 0;

    directed_rows = '{
      '{ms_pkg::MODE_POP,    32'sd0,  1'b1, SUM_EMPTY_ERR},
      '{ms_pkg::MODE_POPMAX, 32'sd0,  1'b1, SUM_EMPTY_ERR},
      '{ms_pkg::MODE_NOP,    32'sd0,  1'b1, SUM_EMPTY_OK},
      '{ms_pkg::MODE_PUSH,   WMAX,    1'b1, '{'0, WMAX, WMAX, 7'd1, 1'b0, ms_pkg::STAT_OK}},
      '{ms_pkg::MODE_PUSH,   WMIN,    1'b1, '{'0, WMIN, WMAX, 7'd2, 1'b0, ms_pkg::STAT_OK}},
      '{ms_pkg::MODE_POPMAX, 32'sd0,  1'b1, '{WMAX, WMIN, WMIN, 7'd1, 1'b0, ms_pkg::STAT_OK}},
      '{ms_pkg::MODE_POP,    32'sd0,  1'b1, '{WMIN, '0, '0, 7'd0, 1'b1, ms_pkg::STAT_OK}},
      '{ms_pkg::MODE_PUSH,   32'sd5,  1'b0, SUM_NONE},
      '{ms_pkg::MODE_PUSH,   32'sd9,  1'b0, SUM_NONE},
      '{ms_pkg::MODE_PUSH,   32'sd3,  1'b0, SUM_NONE},
      '{ms_pkg::MODE_PUSH,   32'sd9,  1'b0, SUM_NONE},
      '{ms_pkg::MODE_PUSH,   32'sd1,  1'b0, SUM_NONE},
      '{ms_pkg::MODE_NOP,    -32'sd1, 1'b0, SUM_NONE},
      '{ms_pkg::MODE_POPMAX, 32'sd0,  1'b0, SUM_NONE},
      '{ms_pkg::MODE_POPMAX, 32'sd0,  1'b0, SUM_NONE},
      '{ms_pkg::MODE_PUSH,   -32'sd1, 1'b0, SUM_NONE},
      '{ms_pkg::MODE_PUSH,   32'sd5,  1'b0, SUM_NONE},
      '{ms_pkg::MODE_POPMAX, 32'sd0,  1'b0, SUM_NONE},
      '{ms_pkg::MODE_POP,    -32'sd1, 1'b0, SUM_NONE},
      '{ms_pkg::MODE_POPMAX, 32'sd0,  1'b0, SUM_NONE},
      '{ms_pkg::MODE_POPMAX, 32'sd0,  1'b0, SUM_NONE},
      '{ms_pkg::MODE_POPMAX, 32'sd0,  1'b0, SUM_NONE},
      '{ms_pkg::MODE_POPMAX, 32'sd0,  1'b1, SUM_EMPTY_ERR},
      '{ms_pkg::MODE_PUSH,   32'sd0,  1'b1, '{'0, '0, '0, 7'd1, 1'b0, ms_pkg::STAT_OK}}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_op(directed_rows[i].mode, directed_rows[i].value,
              directed_rows[i].typed, directed_rows[i].want);

    // first phase fills the stack past full, later phases drift up and down
    sent       = 0;
    push_pct   = 100;
    phase_left = STACK_DEPTH + 3;
    while (sent < RANDOM_OPS) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 4))
          0: push_pct = 100;
          1: push_pct = 85;
          2: push_pct = 50;
          3: push_pct = 15;
          default: push_pct = 0;
        endcase
        phase_left = $urandom_range(30, 120);
        quiet      = ($urandom_range(0, 4) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        m = ms_pkg::MODE_PUSH;
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0) m = ms_pkg::MODE_NOP;
        else if (r < 10) m = ms_pkg::MODE_POPMAX;
        else m = ms_pkg::MODE_POP;
      end
      r = $urandom_range(0, 99);
      if (r < 40) v = $urandom;
      else if (r < 75) v = $signed($urandom_range(0, 8)) - 4;
      else if (r < 85) begin
        case ($urandom_range(0, 3))
          0: v = WMAX;
          1: v = WMIN;
          2: v = 0;
          default: v = -1;
        endcase
      end else v = $signed($urandom_range(0, 2000)) - 1000;
      send_op(m, v, 1'b0, SUM_NONE);
      sent++;
      phase_left--;
    end
    req_ch.valid <= 1'b0;

    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (STACK_DEPTH + 8) @(posedge clk);

    $display("covered %0d push, %0d pop, %0d pop-max and %0d no-op transactions",
             op_count[ms_pkg::MODE_PUSH], op_count[ms_pkg::MODE_POP],
             op_count[ms_pkg::MODE_POPMAX], op_count[ms_pkg::MODE_NOP]);
    $display("push on full %0d times, pop on empty %0d times, deepest stack %0d",
             full_rejects, empty_rejects, deepest);
    if (errors == 0) $display("** max_stack: PASSED **");
    else $display("** max_stack: FAILED **");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d responses outstanding", pending_summaries.size());
    $display("** max_stack: FAILED **");
    $finish;
  end

endmodule
